/* rtl/timestamp_ordered_message_queue_core_assert.svh */
// Assertion shorthands for the message queue checker.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef TIMESTAMP_ORDERED_MESSAGE_QUEUE_CORE_ASSERT_SVH
`define TIMESTAMP_ORDERED_MESSAGE_QUEUE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TOMQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TOMQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tomq_pkg.sv */
`timescale 1ns / 1ps
package tomq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int HANDLE_W = 16;
	localparam int CODE_W   = 32;
	localparam int STAMP_W  = 63;
	localparam int COUNT_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_COUNT   = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_NONE = 2'd2
	} status_t;

	// Oldest-stamp value reported for an empty queue.
	localparam logic [STAMP_W-1:0] STAMP_EMPTY = '1;

	typedef struct packed {
		logic [STAMP_W-1:0]  stamp;
		logic [CODE_W-1:0]   code;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle_out;
		logic [CODE_W-1:0]   code_out;
		logic [STAMP_W-1:0]  stamp_out;
		logic [COUNT_W-1:0]  count;
		logic                more;
		logic [STAMP_W-1:0]  oldest_stamp;
	} result_t;

endpackage

/* rtl/tomq_in_if.sv */
`timescale 1ns / 1ps
interface tomq_in_if import tomq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [HANDLE_W-1:0] handle;
	logic [CODE_W-1:0]   code;
	logic                match_any;
	logic                has_stamp;
	logic [STAMP_W-1:0]  stamp;
	logic [STAMP_W-1:0]  now;

	modport source (
		output valid, cmd, handle, code, match_any, has_stamp, stamp, now,
		input  ready
	);
	modport sink (
		input  valid, cmd, handle, code, match_any, has_stamp, stamp, now,
		output ready
	);
endinterface

/* rtl/tomq_out_if.sv */
`timescale 1ns / 1ps
interface tomq_out_if import tomq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [CODE_W-1:0]   code_out;
	logic [STAMP_W-1:0]  stamp_out;
	logic [COUNT_W-1:0]  count;
	logic                more;
	logic [STAMP_W-1:0]  oldest_stamp;

	modport source (
		output valid, status, handle_out, code_out, stamp_out, count, more, oldest_stamp,
		input  ready
	);
	modport sink (
		input  valid, status, handle_out, code_out, stamp_out, count, more, oldest_stamp,
		output ready
	);
endinterface

/* rtl/timestamp_ordered_message_queue_core.sv */
// Enqueue walks back from the tail past entries with a later stamp (a full queue is rejected
// with no scan); dequeue scans from the head to the first match and closes up the entries
// behind it; count scans every entry; clear only resets occupancy. All end with a head read.
// Throughput: one item at a time; every scan step is a read and an evaluate on the single
// entry memory port pair and the shared compare unit, so cost grows with occupancy.
// Reset: occupancy and control clear at once; entry memory is not cleared (no sweep).
`timescale 1ns / 1ps
module timestamp_ordered_message_queue_core import tomq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tomq_in_if.sink    req,
	tomq_out_if.source rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [OW-1:0] DEPTH_O = OW'(QUEUE_DEPTH);

	// Sequencer states:
	//   S_RD    : issue an entry read (or, for enqueue into slot 0, write directly)
	//   S_EVAL  : read data is back; compare and decide
	//   S_SH_RD : dequeue close-up, read the entry behind the gap
	//   S_SH_EV : dequeue close-up, move it forward one slot
	//   S_HEAD_RD / S_FIN : fetch the head entry for oldest_stamp, publish the result
	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_RD      = 7'b0000010,
		S_EVAL    = 7'b0000100,
		S_SH_RD   = 7'b0001000,
		S_SH_EV   = 7'b0010000,
		S_HEAD_RD = 7'b0100000,
		S_FIN     = 7'b1000000
	} state_t;

	state_t         state_q, state_d;
	cmd_t           cmd_q, cmd_d;
	entry_t         new_q, new_d;       // entry to insert, or code to match
	logic           any_q, any_d;
	logic [OW-1:0]  idx_q, idx_d;       // scan position
	logic [OW-1:0]  occ_q, occ_d;       // number of valid entries
	result_t        res_q, res_d;       // result being built
	result_t        out_q, out_d;       // output register
	logic           out_valid_q, out_valid_d;

	// Entry memory: one write port, one registered read port.
	entry_t         mem_q [QUEUE_DEPTH];
	entry_t         rd_q;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	entry_t         wr_data;

	logic [OW-1:0]  idx_dec;
	logic [OW-1:0]  idx_inc;
	logic [OW-1:0]  occ_inc;
	logic           later;
	logic           match;
	logic           accept;
	logic           out_free;

	assign idx_dec = idx_q - 1'b1;
	assign idx_inc = idx_q + 1'b1;
	assign occ_inc = occ_q + 1'b1;

	// Shared compare unit: stamp order for enqueue, code match for dequeue and count.
	assign later = rd_q.stamp > new_q.stamp;
	assign match = any_q || (rd_q.code == new_q.code);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Memory port control.
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = new_q;
		unique case (state_q)
			S_RD: begin
				if (cmd_q == CMD_ENQUEUE) begin
					// empty slot 0 takes the new entry with no compare
					if (idx_q == '0) begin
						wr_en = 1'b1;
					end else begin
						rd_addr = idx_dec[AW-1:0];
					end
				end else begin
					rd_addr = idx_q[AW-1:0];
				end
			end
			S_EVAL: begin
				// enqueue: either push the later entry back one slot or drop in the new one
				if (cmd_q == CMD_ENQUEUE) begin
					wr_en   = 1'b1;
					wr_data = later ? rd_q : new_q;
				end
			end
			S_SH_RD: begin
				rd_addr = idx_inc[AW-1:0];
			end
			S_SH_EV: begin
				wr_en   = 1'b1;
				wr_data = rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Sequencer and result assembly.
	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		new_d       = new_q;
		any_d       = any_q;
		idx_d       = idx_q;
		occ_d       = occ_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !rsp.ready;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d        = cmd_t'(req.cmd);
					new_d.stamp  = req.has_stamp ? req.stamp : req.now;
					new_d.code   = req.code;
					new_d.handle = req.handle;
					any_d        = req.match_any;
					idx_d        = '0;
					res_d        = '0;
					unique case (cmd_t'(req.cmd))
						CMD_ENQUEUE: begin
							res_d.stamp_out = new_d.stamp;
							if (occ_q == DEPTH_O) begin
								// full: drop the entry, report unchanged occupancy
								res_d.status = STATUS_FULL;
								res_d.count  = COUNT_W'(occ_q);
								state_d      = S_HEAD_RD;
							end else begin
								idx_d   = occ_q;
								state_d = S_RD;
							end
						end
						CMD_DEQUEUE, CMD_COUNT: begin
							state_d = S_RD;
						end
						CMD_CLEAR: begin
							occ_d   = '0;
							state_d = S_HEAD_RD;
						end
						default: begin
						end
					endcase
				end
			end
			S_RD: begin
				if (cmd_q == CMD_ENQUEUE) begin
					if (idx_q == '0) begin
						occ_d       = occ_inc;
						res_d.count = COUNT_W'(occ_inc);
						state_d     = S_HEAD_RD;
					end else begin
						state_d = S_EVAL;
					end
				end else if (idx_q == occ_q) begin
					// scan ran off the end
					if (cmd_q == CMD_DEQUEUE) begin
						res_d.status = STATUS_NONE;
					end
					state_d = S_HEAD_RD;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (cmd_q == CMD_ENQUEUE) begin
					if (later) begin
						idx_d   = idx_dec;
						state_d = S_RD;
					end else begin
						occ_d       = occ_inc;
						res_d.count = COUNT_W'(occ_inc);
						state_d     = S_HEAD_RD;
					end
				end else if (cmd_q == CMD_DEQUEUE) begin
					if (match) begin
						res_d.handle_out = rd_q.handle;
						res_d.code_out   = rd_q.code;
						res_d.stamp_out  = rd_q.stamp;
						state_d          = S_SH_RD;
					end else begin
						idx_d   = idx_inc;
						state_d = S_RD;
					end
				end else begin
					if (match) begin
						res_d.count = res_q.count + 1'b1;
					end
					idx_d   = idx_inc;
					state_d = S_RD;
				end
			end
			S_SH_RD: begin
				// close the gap left by the removed entry, one slot per pass
				if (idx_inc >= occ_q) begin
					occ_d   = occ_q - 1'b1;
					state_d = S_HEAD_RD;
				end else begin
					state_d = S_SH_EV;
				end
			end
			S_SH_EV: begin
				idx_d   = idx_inc;
				state_d = S_SH_RD;
			end
			S_HEAD_RD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				// hold here until the output register is free
				if (out_free) begin
					out_d              = res_q;
					out_d.more         = (occ_q != '0);
					out_d.oldest_stamp = (occ_q != '0) ? rd_q.stamp : STAMP_EMPTY;
					out_valid_d        = 1'b1;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		new_q <= new_d;
		any_q <= any_d;
		res_q <= res_d;
		out_q <= out_d;
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.handle_out   = out_q.handle_out;
	assign rsp.code_out     = out_q.code_out;
	assign rsp.stamp_out    = out_q.stamp_out;
	assign rsp.count        = out_q.count;
	assign rsp.more         = out_q.more;
	assign rsp.oldest_stamp = out_q.oldest_stamp;

endmodule

/* rtl/tomq_checker.sv */
`timescale 1ns / 1ps
`include "timestamp_ordered_message_queue_core_assert.svh"
module tomq_checker import tomq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [HANDLE_W-1:0] handle_out,
	input logic [CODE_W-1:0]   code_out,
	input logic [STAMP_W-1:0]  stamp_out,
	input logic                more,
	input logic [STAMP_W-1:0]  oldest_stamp
);

	`TOMQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid,
		"response lost while stalled")

	`TOMQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
		"took a second item while busy")

	`TOMQ_ASSERT_SAME(a_empty_oldest, rsp_valid && !more, oldest_stamp == STAMP_EMPTY,
		"empty queue without empty stamp")

	`TOMQ_ASSERT_SAME(a_none_zero, rsp_valid && status == STATUS_NONE,
		handle_out == '0 && code_out == '0 && stamp_out == '0,
		"failed dequeue carries entry data")

endmodule

bind timestamp_ordered_message_queue_core tomq_checker u_tomq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.handle_out   (rsp.handle_out),
	.code_out     (rsp.code_out),
	.stamp_out    (rsp.stamp_out),
	.more         (rsp.more),
	.oldest_stamp (rsp.oldest_stamp)
);

/* tb/timestamp_ordered_message_queue_core_tb.sv */
`timescale 1ns / 1ps
module timestamp_ordered_message_queue_core_tb;
	import tomq_pkg::*;

	localparam int DEPTH          = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT    = 1_000_000;
	// Worst case is a count or dequeue at full occupancy with the output stalled.
	localparam int SETTLE_CYCLES  = 100;

	typedef struct {
		cmd_t                cmd;
		logic [HANDLE_W-1:0] handle;
		logic [CODE_W-1:0]   code;
		logic                match_any;
		logic                has_stamp;
		logic [STAMP_W-1:0]  stamp;
		logic [STAMP_W-1:0]  now;
	} request_t;

	// Shadow copy of the sorted queue and the results it predicts.
	class tomq_scoreboard;
		logic [STAMP_W-1:0]  slot_stamp  [DEPTH];
		logic [CODE_W-1:0]   slot_code   [DEPTH];
		logic [HANDLE_W-1:0] slot_handle [DEPTH];
		int unsigned         occupancy;
		result_t             expected_q [$];
		int unsigned         fails;
		int unsigned         checked;
		int unsigned         cmd_seen [4];
		int unsigned         full_seen;
		int unsigned         none_seen;
		int unsigned         peak;

		function new();
			occupancy = 0;
			fails     = 0;
			checked   = 0;
			full_seen = 0;
			none_seen = 0;
			peak      = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply one accepted request to the shadow queue and queue its result.
		function void note_request(request_t r);
			result_t             res;
			logic [STAMP_W-1:0]  s;
			int                  pos;
			int                  i;
			int                  n;
			res = '0;
			cmd_seen[r.cmd]++;
			case (r.cmd)
				CMD_ENQUEUE: begin
					s = r.has_stamp ? r.stamp : r.now;
					res.stamp_out = s;
					if (occupancy >= DEPTH) begin
						res.status = STATUS_FULL;
						res.count  = COUNT_W'(occupancy);
						full_seen++;
					end else begin
						// Insert after every entry whose stamp is not greater.
						pos = occupancy;
						while (pos > 0 && slot_stamp[pos-1] > s) pos--;
						for (i = occupancy; i > pos; i--) begin
							slot_stamp[i]  = slot_stamp[i-1];
							slot_code[i]   = slot_code[i-1];
							slot_handle[i] = slot_handle[i-1];
						end
						slot_stamp[pos]  = s;
						slot_code[pos]   = r.code;
						slot_handle[pos] = r.handle;
						occupancy++;
						res.count = COUNT_W'(occupancy);
					end
				end
				CMD_DEQUEUE: begin
					pos = 0;
					while (pos < occupancy && !(r.match_any || slot_code[pos] == r.code)) pos++;
					if (pos >= occupancy) begin
						res.status = STATUS_NONE;
						none_seen++;
					end else begin
						res.handle_out = slot_handle[pos];
						res.code_out   = slot_code[pos];
						res.stamp_out  = slot_stamp[pos];
						for (i = pos; i + 1 < occupancy; i++) begin
							slot_stamp[i]  = slot_stamp[i+1];
							slot_code[i]   = slot_code[i+1];
							slot_handle[i] = slot_handle[i+1];
						end
						occupancy--;
					end
				end
				CMD_COUNT: begin
					n = 0;
					for (i = 0; i < occupancy; i++)
						if (r.match_any || slot_code[i] == r.code) n++;
					res.count = COUNT_W'(n);
				end
				default: begin
					occupancy = 0;
				end
			endcase
			if (occupancy > peak) peak = occupancy;
			res.more         = (occupancy != 0);
			res.oldest_stamp = (occupancy != 0) ? slot_stamp[0] : STAMP_EMPTY;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
			if (act !== exp) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp, act);
				fails++;
			end
		endfunction

		// Compare one response transfer against the oldest prediction.
		function void check_response(result_t got);
			result_t exp;
			if (expected_q.size() == 0) begin
				$error("response with nothing outstanding: status 0x%0h", got.status);
				fails++;
				return;
			end
			exp = expected_q.pop_front();
			checked++;
			compare_field("status",       64'(exp.status),       64'(got.status));
			compare_field("handle_out",   64'(exp.handle_out),   64'(got.handle_out));
			compare_field("code_out",     64'(exp.code_out),     64'(got.code_out));
			compare_field("stamp_out",    64'(exp.stamp_out),    64'(got.stamp_out));
			compare_field("count",        64'(exp.count),        64'(got.count));
			compare_field("more",         64'(exp.more),         64'(got.more));
			compare_field("oldest_stamp", 64'(exp.oldest_stamp), 64'(got.oldest_stamp));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tomq_in_if  req_if ();
	tomq_out_if rsp_if ();

	timestamp_ordered_message_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	tomq_scoreboard board = new();

	// Shared switch for random stalls on both sides of the block.
	bit          idle_on;
	int unsigned cycle_cnt;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_cnt, board.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Response side: hold ready low in random bursts while idling is enabled.
	initial begin
		int stall;
		stall = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!idle_on) stall = 0;
			if (stall == 0 && idle_on && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 11);
			if (stall > 0) begin
				stall--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Sample a response transfer with the values held before the edge.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status       = status_t'(rsp_if.status);
			got.handle_out   = rsp_if.handle_out;
			got.code_out     = rsp_if.code_out;
			got.stamp_out    = rsp_if.stamp_out;
			got.count        = rsp_if.count;
			got.more         = rsp_if.more;
			got.oldest_stamp = rsp_if.oldest_stamp;
			board.check_response(got);
		end
	end

	function automatic logic [STAMP_W-1:0] rand_wide();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[STAMP_W-1:0];
	endfunction

	// Mostly small stamps so that ties and mid-queue inserts are common.
	function automatic logic [STAMP_W-1:0] pick_stamp();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)  return STAMP_W'($urandom_range(0, 31));
		if (k < 7)  return rand_wide();
		if (k == 7) return STAMP_EMPTY;
		if (k == 8) return '0;
		return STAMP_EMPTY - STAMP_W'($urandom_range(1, 7));
	endfunction

	// Draw codes from a small pool so that matches happen often.
	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(0, 7))
			0, 1:    return 32'h0000_0000;
			2, 3:    return 32'hFFFF_FFFF;
			4:       return 32'h0000_0001;
			5:       return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic request_t make_request(cmd_t c, logic [HANDLE_W-1:0] h,
			logic [CODE_W-1:0] cd, logic any, logic hs, logic [STAMP_W-1:0] st,
			logic [STAMP_W-1:0] nw);
		request_t r;
		r.cmd       = c;
		r.handle    = h;
		r.code      = cd;
		r.match_any = any;
		r.has_stamp = hs;
		r.stamp     = st;
		r.now       = nw;
		return r;
	endfunction

	function automatic request_t random_request(int w_enq, int w_deq, int w_cnt);
		request_t r;
		int       roll;
		roll = $urandom_range(0, 99);
		if (roll < w_enq)                     r.cmd = CMD_ENQUEUE;
		else if (roll < w_enq + w_deq)        r.cmd = CMD_DEQUEUE;
		else if (roll < w_enq + w_deq + w_cnt) r.cmd = CMD_COUNT;
		else                                  r.cmd = CMD_CLEAR;
		r.handle    = HANDLE_W'($urandom());
		r.code      = pick_code();
		r.match_any = $urandom_range(0, 1);
		r.has_stamp = $urandom_range(0, 1);
		r.stamp     = pick_stamp();
		r.now       = pick_stamp();
		return r;
	endfunction

	// Present one request and hold it until the transfer completes.
	task automatic transfer_request(input request_t r);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.cmd       <= r.cmd;
		req_if.handle    <= r.handle;
		req_if.code      <= r.code;
		req_if.match_any <= r.match_any;
		req_if.has_stamp <= r.has_stamp;
		req_if.stamp     <= r.stamp;
		req_if.now       <= r.now;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
		board.note_request(r);
	endtask

	// Stop sending and wait until every predicted response has arrived.
	task automatic drain();
		req_if.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic run_random(int n, int w_enq, int w_deq, int w_cnt, bit allow_idle);
		int i;
		for (i = 0; i < n; i++) begin
			// Every 40 requests, pick at random a stretch with or without stalls.
			if (i % 40 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			transfer_request(random_request(w_enq, w_deq, w_cnt));
		end
	endtask

	initial begin
		int i;
		idle_on          = 1'b0;
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.cmd       <= CMD_ENQUEUE;
		req_if.handle    <= '0;
		req_if.code      <= '0;
		req_if.match_any <= 1'b0;
		req_if.has_stamp <= 1'b0;
		req_if.stamp     <= '0;
		req_if.now       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, extreme fields, ties, selective ops, clear.
		transfer_request(make_request(CMD_DEQUEUE, '1, '1, 1'b1, 1'b1, '1, '1));
		transfer_request(make_request(CMD_COUNT, '0, '0, 1'b1, 1'b0, '0, '0));
		transfer_request(make_request(CMD_ENQUEUE, '1, '1, 1'b0, 1'b1, STAMP_EMPTY, '0));
		transfer_request(make_request(CMD_ENQUEUE, '0, '0, 1'b1, 1'b0, STAMP_EMPTY, '0));
		transfer_request(make_request(CMD_ENQUEUE, 16'h1111, 32'hA, 1'b0, 1'b1, 63'd5,
			STAMP_EMPTY));
		transfer_request(make_request(CMD_ENQUEUE, 16'h2222, 32'hB, 1'b0, 1'b1, 63'd5, '0));
		transfer_request(make_request(CMD_COUNT, '0, 32'hA, 1'b0, 1'b0, '0, '0));
		transfer_request(make_request(CMD_DEQUEUE, '0, 32'hB, 1'b0, 1'b0, '0, '0));
		transfer_request(make_request(CMD_DEQUEUE, '0, 32'h12345, 1'b0, 1'b0, '0, '0));
		transfer_request(make_request(CMD_CLEAR, '0, '0, 1'b0, 1'b0, '0, '0));
		// Fill to capacity, then push once more against a full queue.
		for (i = 0; i < DEPTH; i++)
			transfer_request(make_request(CMD_ENQUEUE, HANDLE_W'(i), pick_code(), 1'b0,
				$urandom_range(0, 1), STAMP_W'($urandom_range(0, 7)),
				STAMP_W'($urandom_range(0, 7))));
		transfer_request(make_request(CMD_ENQUEUE, 16'hBEEF, '1, 1'b0, 1'b0, '0, STAMP_EMPTY));
		transfer_request(make_request(CMD_COUNT, '0, '0, 1'b1, 1'b0, '0, '0));
		drain();

		// Random phases: balanced, filling, emptying, then balanced with no stalls.
		run_random(400, 45, 30, 20, 1'b1);
		drain();
		run_random(300, 70, 15, 13, 1'b1);
		drain();
		run_random(300, 30, 50, 18, 1'b1);
		drain();
		run_random(320, 45, 30, 20, 1'b0);

		req_if.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d responses: %0d enqueue, %0d dequeue, %0d count, %0d clear",
			board.checked, board.cmd_seen[CMD_ENQUEUE], board.cmd_seen[CMD_DEQUEUE],
			board.cmd_seen[CMD_COUNT], board.cmd_seen[CMD_CLEAR]);
		$display("full rejections %0d, empty or unmatched dequeues %0d, peak depth %0d",
			board.full_seen, board.none_seen, board.peak);
		if (board.fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
